// ===== rtl/fsd_pkg.sv =====
package fsd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned ERR_W       = 9;
  localparam int unsigned LANES       = 3;
  localparam int unsigned STORE_W     = ERR_W * LANES;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_LEVELS_RED   = 3'd2,
    CFG_LEVELS_GREEN = 3'd3,
    CFG_LEVELS_BLUE  = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [12:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  levels_red;
    logic [7:0]  levels_green;
    logic [7:0]  levels_blue;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_pixel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FETCH2,
    ST_UPPER,
    ST_LEFT,
    ST_LEVEL,
    ST_QUANT
  } state_e;

  typedef struct packed {
    logic accept;
    logic fetch_second;
    logic win_shift;
    logic win_right;
    logic upper;
    logic left;
    logic level;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic has_left;
    logic has_right;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/fsd_ram.sv =====
module fsd_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fsd_ctrl.sv =====
module fsd_ctrl import fsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // The first column of a wider row needs two line-buffer reads.
        if (!status_i.has_left && status_i.has_right) begin
          cmd_o.fetch_second = 1'b1;
          state_d            = ST_FETCH2;
        end else begin
          cmd_o.win_shift = 1'b1;
          state_d         = ST_UPPER;
        end
      end
      ST_FETCH2: begin
        cmd_o.win_right = 1'b1;
        state_d         = ST_UPPER;
      end
      ST_UPPER: begin
        cmd_o.upper = 1'b1;
        state_d     = ST_LEFT;
      end
      ST_LEFT: begin
        cmd_o.left = 1'b1;
        state_d    = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd_o.level = 1'b1;
        state_d     = ST_QUANT;
      end
      ST_QUANT: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fsd_datapath.sv =====
module fsd_datapath import fsd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  input  in_pixel_t                    in_data_i,
  output out_pixel_t                   out_data_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         mem_re_o,
  output logic [$clog2(MAX_WIDTH)-1:0] mem_raddr_o,
  input  logic [STORE_W-1:0]           mem_rdata_i,
  output logic                         mem_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0] mem_waddr_o,
  output logic [STORE_W-1:0]           mem_wdata_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // Adds one diffused term sign(e)*((|e|*k+8)>>4) and clamps to 0..255.
  function automatic logic [7:0] add_term(input logic [7:0] c, input logic [ERR_W-1:0] e,
                                          input logic [2:0] k);
    logic [ERR_W-1:0] mag;
    logic [11:0]      t;
    logic signed [12:0] r;
    mag = e[ERR_W-1] ? (~e + 9'd1) : e;
    t   = (12'(mag) * 12'(k) + 12'd8) >> 4;
    if (e[ERR_W-1]) begin
      r = $signed({5'b0, c}) - $signed({1'b0, t});
    end else begin
      r = $signed({5'b0, c}) + $signed({1'b0, t});
    end
    if (r < 0) begin
      return 8'd0;
    end else if (r > 13'sd255) begin
      return 8'd255;
    end
    return r[7:0];
  endfunction

  // Quantizer step floor(255/m) for m = 1..254.
  function automatic logic [7:0] step_of(input logic [7:0] m);
    logic [7:0] s;
    priority if (m >= 8'd128) s = 8'd1;
    else if (m >= 8'd86) s = 8'd2;
    else if (m >= 8'd64) s = 8'd3;
    else if (m >= 8'd52) s = 8'd4;
    else if (m >= 8'd43) s = 8'd5;
    else if (m >= 8'd37) s = 8'd6;
    else if (m >= 8'd32) s = 8'd7;
    else if (m >= 8'd29) s = 8'd8;
    else if (m >= 8'd26) s = 8'd9;
    else if (m >= 8'd24) s = 8'd10;
    else if (m >= 8'd22) s = 8'd11;
    else if (m >= 8'd20) s = 8'd12;
    else if (m == 8'd19) s = 8'd13;
    else if (m == 8'd18) s = 8'd14;
    else if (m >= 8'd16) s = 8'd15;
    else if (m == 8'd15) s = 8'd17;
    else if (m == 8'd14) s = 8'd18;
    else if (m == 8'd13) s = 8'd19;
    else if (m == 8'd12) s = 8'd21;
    else if (m == 8'd11) s = 8'd23;
    else if (m == 8'd10) s = 8'd25;
    else if (m == 8'd9) s = 8'd28;
    else if (m == 8'd8) s = 8'd31;
    else if (m == 8'd7) s = 8'd36;
    else if (m == 8'd6) s = 8'd42;
    else if (m == 8'd5) s = 8'd51;
    else if (m == 8'd4) s = 8'd63;
    else if (m == 8'd3) s = 8'd85;
    else if (m == 8'd2) s = 8'd127;
    else s = 8'd255;
    return s;
  endfunction

  // Position and frame state.
  logic [CW-1:0] col_cnt_q, col_cnt_d;
  logic [15:0]   row_cnt_q, row_cnt_d;
  logic [CW-1:0] cur_col_q;
  logic          has_up_q, has_left_q, has_right_q;

  // Per-lane payload.
  logic [LANES-1:0][7:0]       pix_q, c_q, level_q, step_q, out_q;
  logic [LANES-1:0][16:0]      x_q;
  logic [LANES-1:0][ERR_W-1:0] left_err_q, fresh_err;
  logic [STORE_W-1:0]          up_left_q, up_mid_q, up_right_q;
  logic                        out_valid_q;

  logic [31:0]   w_wide;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic          wrap;
  logic [CW-1:0] col_eff;
  logic [WW-1:0] col_p1;
  logic [16:0]   row1;
  logic [16:0]   row_p1;
  logic [15:0]   row_eff;
  logic          acc_has_right;
  logic [CW-1:0] acc_raddr;

  logic [LANES-1:0][7:0] m_lane;
  logic [LANES-1:0][7:0] c_upper, c_left, level_d, q_lane;
  logic [LANES-1:0][16:0] x_d;

  always_comb begin
    w_wide = 32'(cfg_i.image_width);
    if (w_wide == 32'd0) begin
      w_wide = 32'd1;
    end else if (w_wide > 32'(MAX_WIDTH)) begin
      w_wide = 32'(MAX_WIDTH);
    end
    w_eff = WW'(w_wide);
    h_eff = (cfg_i.image_height == 16'd0) ? 16'd1 : cfg_i.image_height;

    // A counter left beyond a narrowed width starts the next row.
    wrap    = WW'(col_cnt_q) >= w_eff;
    col_eff = wrap ? '0 : col_cnt_q;
    row1    = wrap ? (17'(row_cnt_q) + 17'd1) : 17'(row_cnt_q);
    row_eff = (row1 >= 17'(h_eff)) ? 16'd0 : row1[15:0];
    col_p1  = WW'(col_eff) + WW'(1);
    row_p1  = 17'(row_eff) + 17'd1;
    acc_has_right = col_p1 < w_eff;

    if (acc_has_right) begin
      col_cnt_d = col_p1[CW-1:0];
      row_cnt_d = row_eff;
    end else begin
      col_cnt_d = '0;
      row_cnt_d = (row_p1 >= 17'(h_eff)) ? 16'd0 : row_p1[15:0];
    end

    // Column zero reads its own entry first; later columns read one ahead, the last its own.
    if (col_eff == '0) begin
      acc_raddr = '0;
    end else if (acc_has_right) begin
      acc_raddr = col_p1[CW-1:0];
    end else begin
      acc_raddr = col_eff;
    end
  end

  assign mem_re_o    = cmd_i.accept | cmd_i.fetch_second;
  assign mem_raddr_o = cmd_i.fetch_second ? CW'(1) : acc_raddr;

  always_comb begin
    m_lane[0] = (cfg_i.levels_red < 8'd2) ? 8'd1 : (cfg_i.levels_red - 8'd1);
    m_lane[1] = (cfg_i.levels_green < 8'd2) ? 8'd1 : (cfg_i.levels_green - 8'd1);
    m_lane[2] = (cfg_i.levels_blue < 8'd2) ? 8'd1 : (cfg_i.levels_blue - 8'd1);
  end

  always_comb begin
    logic [15:0] prod;
    logic [15:0] y;
    logic [24:0] p;
    logic [7:0]  q0;
    logic [15:0] q0_255;
    logic [16:0] rem;
    logic [15:0] qprod;
    for (int ch = 0; ch < LANES; ch++) begin
      c_upper[ch] = pix_q[ch];
      if (has_up_q) begin
        if (has_left_q) begin
          c_upper[ch] = add_term(c_upper[ch], up_left_q[ch*ERR_W +: ERR_W], 3'd1);
        end
        c_upper[ch] = add_term(c_upper[ch], up_mid_q[ch*ERR_W +: ERR_W], 3'd5);
        if (has_right_q) begin
          c_upper[ch] = add_term(c_upper[ch], up_right_q[ch*ERR_W +: ERR_W], 3'd3);
        end
      end

      c_left[ch] = has_left_q ? add_term(c_q[ch], left_err_q[ch], 3'd7) : c_q[ch];
      prod       = 16'(c_left[ch]) * 16'(m_lane[ch]);
      x_d[ch]    = {prod, 1'b0} + 17'd255;

      // floor(x/510) = floor((x>>1)/255): reciprocal estimate, one correction.
      y           = x_q[ch][16:1];
      p           = 25'({y, 8'b0}) + 25'(y);
      q0          = p[23:16];
      q0_255      = 16'({q0, 8'b0}) - 16'(q0);
      rem         = 17'(y) - 17'(q0_255);
      level_d[ch] = (rem >= 17'd255) ? (q0 + 8'd1) : q0;

      qprod         = 16'(level_q[ch]) * 16'(step_q[ch]);
      q_lane[ch]    = qprod[7:0];
      fresh_err[ch] = {1'b0, c_q[ch]} - {1'b0, q_lane[ch]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      left_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      if (cmd_i.finish) begin
        left_err_q  <= fresh_err;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q[0]    <= in_data_i.red_in;
      pix_q[1]    <= in_data_i.green_in;
      pix_q[2]    <= in_data_i.blue_in;
      cur_col_q   <= col_eff;
      has_up_q    <= row_eff != 16'd0;
      has_left_q  <= col_eff != '0;
      has_right_q <= acc_has_right;
    end
    if (cmd_i.fetch_second) begin
      up_mid_q <= mem_rdata_i;
    end
    if (cmd_i.win_shift) begin
      if (!has_left_q) begin
        up_mid_q   <= mem_rdata_i;
        up_right_q <= '0;
      end else begin
        // The previous pixel already read this column's upper entry.
        up_left_q  <= up_mid_q;
        up_mid_q   <= up_right_q;
        up_right_q <= has_right_q ? mem_rdata_i : '0;
      end
    end
    if (cmd_i.win_right) begin
      up_right_q <= mem_rdata_i;
    end
    if (cmd_i.upper) begin
      c_q <= c_upper;
    end
    if (cmd_i.left) begin
      c_q <= c_left;
      x_q <= x_d;
    end
    if (cmd_i.level) begin
      level_q <= level_d;
      for (int ch = 0; ch < LANES; ch++) begin
        step_q[ch] <= step_of(m_lane[ch]);
      end
    end
    if (cmd_i.finish) begin
      out_q <= q_lane;
    end
  end

  assign mem_we_o    = cmd_i.finish;
  assign mem_waddr_o = cur_col_q;
  assign mem_wdata_o = fresh_err;

  assign out_valid_o          = out_valid_q;
  assign out_data_o.red_out   = out_q[0];
  assign out_data_o.green_out = out_q[1];
  assign out_data_o.blue_out  = out_q[2];

  assign status_o.has_left  = has_left_q;
  assign status_o.has_right = has_right_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/floyd_steinberg_rgb_dither.sv =====
// Floyd-Steinberg error-diffusion dither for an RGB pixel stream in raster order. A new
// pixel is taken only after the previous one has left the sequencer, which steps each
// pixel through the line-buffer fetch, the upper error terms, the left error term and the
// two quantizer multiplies, since the error of one pixel feeds the next. At the first
// column of a row wider than one pixel the line buffer is read twice through its single
// read port, in an extra fetch state. The result sits in an output register, so a
// stalled consumer holds only the final step. The previous row's errors live in a
// MAX_WIDTH-entry RAM that is not cleared; the entries for the image width are written
// by the first row of a frame before any row uses them. Configuration writes take effect
// immediately and are meant to happen while no transaction is in flight.
module floyd_steinberg_rgb_dither import fsd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_pixel_t              in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_pixel_t             out_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  logic               mem_re, mem_we;
  logic [CW-1:0]      mem_raddr, mem_waddr;
  logic [STORE_W-1:0] mem_rdata, mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 16'd480;
      cfg_q.levels_red   <= 8'd6;
      cfg_q.levels_green <= 8'd6;
      cfg_q.levels_blue  <= 8'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i[12:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i;
        CFG_LEVELS_RED:   cfg_q.levels_red   <= cfg_wdata_i[7:0];
        CFG_LEVELS_GREEN: cfg_q.levels_green <= cfg_wdata_i[7:0];
        CFG_LEVELS_BLUE:  cfg_q.levels_blue  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  fsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fsd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  fsd_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
